// File: hw/rtl/tse_pkg.sv
package tse_pkg;

    localparam int ACTION_W = 3;
    localparam int HOURS_W  = 5;
    localparam int MINSEC_W = 6;
    localparam int CURSOR_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 3'd0,
        ACT_RIGHT   = 3'd1,
        ACT_LEFT    = 3'd2,
        ACT_UP      = 3'd3,
        ACT_DOWN    = 3'd4,
        ACT_CONFIRM = 3'd5,
        ACT_EXIT    = 3'd6
    } t_action;

    localparam logic [CURSOR_W-1:0] POS_HOUR_T = 3'd0;
    localparam logic [CURSOR_W-1:0] POS_HOUR_U = 3'd1;
    localparam logic [CURSOR_W-1:0] POS_MIN_T  = 3'd2;
    localparam logic [CURSOR_W-1:0] POS_MIN_U  = 3'd3;
    localparam logic [CURSOR_W-1:0] POS_SEC_T  = 3'd4;
    localparam logic [CURSOR_W-1:0] POS_SEC_U  = 3'd5;

    localparam logic [HOURS_W-1:0]  HOURS_MAX  = 5'd23;
    localparam logic [MINSEC_W-1:0] MINSEC_MAX = 6'd59;

    localparam logic [3:0] HOUR_TENS_LIM = 4'd2;
    localparam logic [3:0] TENS_LIM      = 4'd5;
    localparam logic [3:0] UNITS_LIM     = 4'd9;

    // step one decimal digit of a two-digit value, wrapping in [0, lim]
    function automatic logic [6:0] step_digit(
        input logic [MINSEC_W-1:0] value,
        input logic                tens,
        input logic [3:0]          lim,
        input logic                up
    );
        logic [13:0] prod;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [3:0]  d;
        prod = 14'(value) * 14'd205;
        hi   = 4'(prod >> 11);
        lo   = 4'(value - 6'({2'b00, hi} * 6'd10));
        d    = tens ? hi : lo;
        if (up) begin
            d = (d >= lim) ? 4'd0 : d + 4'd1;
        end else begin
            d = (d == 4'd0 || d > lim) ? lim : d - 4'd1;
        end
        return tens ? (7'(d) * 7'd10 + 7'(lo)) : (7'(hi) * 7'd10 + 7'(d));
    endfunction

endpackage

// File: hw/rtl/time_setting_digit_editor.sv
// Channel | Valid        | Stall        | Payload
// request | i_in_valid   | o_in_stall   | i_action, i_load_hours/minutes/seconds
// result  | o_out_valid  | i_out_stall  | o_shown_*, o_cursor_position, o_commit
//
// One request per cycle sustained while the result side does not stall; a request is
// taken into the input register, then its result into the edit state / result register.
// The digit update is one short combinational step between the two registers.
// Reset is synchronous: edit time and cursor clear to zero, both stages empty.
// A stalled result holds; the input register still takes a request while it is
// empty or the result register is free or being taken.
module time_setting_digit_editor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tse_pkg::ACTION_W-1:0]   i_action,
    input  logic [tse_pkg::HOURS_W-1:0]    i_load_hours,
    input  logic [tse_pkg::MINSEC_W-1:0]   i_load_minutes,
    input  logic [tse_pkg::MINSEC_W-1:0]   i_load_seconds,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tse_pkg::HOURS_W-1:0]    o_shown_hours,
    output logic [tse_pkg::MINSEC_W-1:0]   o_shown_minutes,
    output logic [tse_pkg::MINSEC_W-1:0]   o_shown_seconds,
    output logic [tse_pkg::CURSOR_W-1:0]   o_cursor_position,
    output logic                           o_commit
);
    import tse_pkg::*;

    logic                r_in_vld;
    logic [ACTION_W-1:0] r_action;
    logic [HOURS_W-1:0]  r_load_h;
    logic [MINSEC_W-1:0] r_load_m;
    logic [MINSEC_W-1:0] r_load_s;

    logic                r_out_vld;
    logic [HOURS_W-1:0]  r_edit_h;
    logic [MINSEC_W-1:0] r_edit_m;
    logic [MINSEC_W-1:0] r_edit_s;
    logic [CURSOR_W-1:0] r_cursor;
    logic                r_commit;

    logic [HOURS_W-1:0]  n_edit_h;
    logic [MINSEC_W-1:0] n_edit_m;
    logic [MINSEC_W-1:0] n_edit_s;
    logic [CURSOR_W-1:0] n_cursor;
    logic                n_commit;
    logic [6:0]          hours_wide;
    logic                out_adv;
    logic                in_take;

    assign out_adv    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !out_adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (out_adv || !r_in_vld) begin
            r_in_vld <= i_in_valid;
        end
        if (in_take) begin
            r_action <= i_action;
            r_load_h <= i_load_hours;
            r_load_m <= i_load_minutes;
            r_load_s <= i_load_seconds;
        end
    end

    always_comb begin
        n_edit_h   = r_edit_h;
        n_edit_m   = r_edit_m;
        n_edit_s   = r_edit_s;
        n_cursor   = r_cursor;
        n_commit   = 1'b0;
        hours_wide = 7'(r_edit_h);
        case (r_action)
            ACT_LOAD: begin
                n_edit_h = (r_load_h > HOURS_MAX)  ? HOURS_MAX  : r_load_h;
                n_edit_m = (r_load_m > MINSEC_MAX) ? MINSEC_MAX : r_load_m;
                n_edit_s = (r_load_s > MINSEC_MAX) ? MINSEC_MAX : r_load_s;
            end
            ACT_RIGHT: begin
                n_cursor = (r_cursor >= POS_SEC_U) ? POS_HOUR_T : r_cursor + 3'd1;
            end
            ACT_LEFT: begin
                n_cursor = (r_cursor == POS_HOUR_T) ? POS_SEC_U : r_cursor - 3'd1;
            end
            ACT_UP, ACT_DOWN: begin
                case (r_cursor)
                    POS_HOUR_T: hours_wide = step_digit(6'(r_edit_h), 1'b1,
                                    HOUR_TENS_LIM, r_action == ACT_UP);
                    POS_HOUR_U: hours_wide = step_digit(6'(r_edit_h), 1'b0,
                                    UNITS_LIM, r_action == ACT_UP);
                    POS_MIN_T:  n_edit_m = 6'(step_digit(r_edit_m, 1'b1,
                                    TENS_LIM, r_action == ACT_UP));
                    POS_MIN_U:  n_edit_m = 6'(step_digit(r_edit_m, 1'b0,
                                    UNITS_LIM, r_action == ACT_UP));
                    POS_SEC_T:  n_edit_s = 6'(step_digit(r_edit_s, 1'b1,
                                    TENS_LIM, r_action == ACT_UP));
                    POS_SEC_U:  n_edit_s = 6'(step_digit(r_edit_s, 1'b0,
                                    UNITS_LIM, r_action == ACT_UP));
                    default: ;
                endcase
                n_edit_h = (hours_wide > 7'(HOURS_MAX)) ? HOURS_MAX : 5'(hours_wide);
            end
            ACT_CONFIRM: begin
                n_commit = 1'b1;
                n_cursor = POS_HOUR_T;
            end
            ACT_EXIT: begin
                n_cursor = POS_HOUR_T;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_edit_h  <= '0;
            r_edit_m  <= '0;
            r_edit_s  <= '0;
            r_cursor  <= '0;
            r_commit  <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_edit_h <= n_edit_h;
                r_edit_m <= n_edit_m;
                r_edit_s <= n_edit_s;
                r_cursor <= n_cursor;
                r_commit <= n_commit;
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_shown_hours     = r_edit_h;
    assign o_shown_minutes   = r_edit_m;
    assign o_shown_seconds   = r_edit_s;
    assign o_cursor_position = r_cursor;
    assign o_commit          = r_commit;

    a_commit_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_commit |-> o_cursor_position == POS_HOUR_T)
        else $error("commit with cursor away from home");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_shown_hours <= HOURS_MAX && o_shown_minutes <= MINSEC_MAX
                        && o_shown_seconds <= MINSEC_MAX)
        else $error("edited time out of range");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_position <= POS_SEC_U)
        else $error("cursor out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld)
        else $error("input stalled with room in the pipe");

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 475;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int NUM_ROWS = 26;

    typedef struct packed {
        logic [HOURS_W-1:0]  hours;
        logic [MINSEC_W-1:0] minutes;
        logic [MINSEC_W-1:0] seconds;
        logic [CURSOR_W-1:0] cursor;
        logic                commit;
    } t_shown;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [HOURS_W-1:0]  lh;
        logic [MINSEC_W-1:0] lm;
        logic [MINSEC_W-1:0] ls;
        bit                  typed;
        t_shown              want;
    } t_row;

    // typed rows carry their expected result; the rest go through the predictor
    t_row script [NUM_ROWS] = '{
        '{ACT_EXIT,    5'd0,  6'd0,  6'd0,  1'b1, {5'd0,  6'd0,  6'd0,  3'd0, 1'b0}},
        '{ACT_UNUSED,  5'd31, 6'd63, 6'd63, 1'b1, {5'd0,  6'd0,  6'd0,  3'd0, 1'b0}},
        '{ACT_LOAD,    5'd31, 6'd63, 6'd63, 1'b1, {5'd23, 6'd59, 6'd59, 3'd0, 1'b0}},
        '{ACT_UP,      5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_LOAD,    5'd23, 6'd59, 6'd59, 1'b1, {5'd23, 6'd59, 6'd59, 3'd0, 1'b0}},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_LEFT,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_UP,      5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_RIGHT,   5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_RIGHT,   5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_LOAD,    5'd19, 6'd0,  6'd0,  1'b0, '0},
        '{ACT_UP,      5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_LEFT,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_UP,      5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_LOAD,    5'd24, 6'd60, 6'd60, 1'b1, {5'd23, 6'd59, 6'd59, 3'd0, 1'b0}},
        '{ACT_LOAD,    5'd0,  6'd0,  6'd0,  1'b1, {5'd0,  6'd0,  6'd0,  3'd0, 1'b0}},
        '{ACT_RIGHT,   5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_RIGHT,   5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_RIGHT,   5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_DOWN,    5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_CONFIRM, 5'd0,  6'd0,  6'd0,  1'b0, '0},
        '{ACT_EXIT,    5'd0,  6'd0,  6'd0,  1'b0, '0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action;
    logic [HOURS_W-1:0]  i_load_hours;
    logic [MINSEC_W-1:0] i_load_minutes;
    logic [MINSEC_W-1:0] i_load_seconds;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [HOURS_W-1:0]  o_shown_hours;
    logic [MINSEC_W-1:0] o_shown_minutes;
    logic [MINSEC_W-1:0] o_shown_seconds;
    logic [CURSOR_W-1:0] o_cursor_position;
    logic                o_commit;

    time_setting_digit_editor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_load_hours      (i_load_hours),
        .i_load_minutes    (i_load_minutes),
        .i_load_seconds    (i_load_seconds),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_shown_hours     (o_shown_hours),
        .o_shown_minutes   (o_shown_minutes),
        .o_shown_seconds   (o_shown_seconds),
        .o_cursor_position (o_cursor_position),
        .o_commit          (o_commit)
    );

    // edit time as the block should hold it
    logic [HOURS_W-1:0]  ed_hours;
    logic [MINSEC_W-1:0] ed_minutes;
    logic [MINSEC_W-1:0] ed_seconds;
    logic [CURSOR_W-1:0] ed_cursor;

    t_shown expected_shown_q [$];
    int     mismatches;
    int     results_seen;
    int     requests_sent;
    int     quiet_requests;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [MINSEC_W-1:0] bump_digit(input logic [MINSEC_W-1:0] value,
                                                       input bit tens, input int lim,
                                                       input bit up);
        int hi;
        int lo;
        int d;
        hi = value / 10;
        lo = value % 10;
        d = tens ? hi : lo;
        if (up) begin
            d = (d >= lim) ? 0 : d + 1;
        end else begin
            d = (d == 0 || d > lim) ? lim : d - 1;
        end
        return tens ? MINSEC_W'(d * 10 + lo) : MINSEC_W'(hi * 10 + d);
    endfunction

    function automatic t_shown apply_request(input logic [ACTION_W-1:0] act,
                                             input logic [HOURS_W-1:0] lh,
                                             input logic [MINSEC_W-1:0] lm,
                                             input logic [MINSEC_W-1:0] ls);
        t_shown res;
        bit     up;
        logic   commit;
        commit = 1'b0;
        case (act)
            ACT_LOAD: begin
                ed_hours   = (lh > HOURS_MAX) ? HOURS_MAX : lh;
                ed_minutes = (lm > MINSEC_MAX) ? MINSEC_MAX : lm;
                ed_seconds = (ls > MINSEC_MAX) ? MINSEC_MAX : ls;
            end
            ACT_RIGHT: ed_cursor = (ed_cursor >= POS_SEC_U) ? POS_HOUR_T : ed_cursor + 3'd1;
            ACT_LEFT:  ed_cursor = (ed_cursor == POS_HOUR_T) ? POS_SEC_U : ed_cursor - 3'd1;
            ACT_UP, ACT_DOWN: begin
                up = (act == ACT_UP);
                case (ed_cursor)
                    POS_HOUR_T: ed_hours = HOURS_W'(bump_digit({1'b0, ed_hours}, 1'b1,
                                                               HOUR_TENS_LIM, up));
                    POS_HOUR_U: ed_hours = HOURS_W'(bump_digit({1'b0, ed_hours}, 1'b0,
                                                               UNITS_LIM, up));
                    POS_MIN_T:  ed_minutes = bump_digit(ed_minutes, 1'b1, TENS_LIM, up);
                    POS_MIN_U:  ed_minutes = bump_digit(ed_minutes, 1'b0, UNITS_LIM, up);
                    POS_SEC_T:  ed_seconds = bump_digit(ed_seconds, 1'b1, TENS_LIM, up);
                    POS_SEC_U:  ed_seconds = bump_digit(ed_seconds, 1'b0, UNITS_LIM, up);
                    default: ;
                endcase
                if (ed_hours > HOURS_MAX) ed_hours = HOURS_MAX;
            end
            ACT_CONFIRM: begin
                commit = 1'b1;
                ed_cursor = POS_HOUR_T;
            end
            ACT_EXIT: ed_cursor = POS_HOUR_T;
            default: ;
        endcase
        res.hours   = ed_hours;
        res.minutes = ed_minutes;
        res.seconds = ed_seconds;
        res.cursor  = ed_cursor;
        res.commit  = commit;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_requests > 0) begin
            quiet_requests--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet_requests = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [HOURS_W-1:0] lh,
                                input logic [MINSEC_W-1:0] lm, input logic [MINSEC_W-1:0] ls,
                                input bit typed, input t_shown want);
        int     gap;
        t_shown predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_action       = act;
        i_load_hours   = lh;
        i_load_minutes = lm;
        i_load_seconds = ls;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_request(act, lh, lm, ls);
        expected_shown_q.push_back(typed ? want : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic [ACTION_W-1:0] act);
        logic [HOURS_W-1:0]  lh;
        logic [MINSEC_W-1:0] lm;
        logic [MINSEC_W-1:0] ls;
        lh = HOURS_W'($urandom);
        lm = MINSEC_W'($urandom);
        ls = MINSEC_W'($urandom);
        if (act == ACT_LOAD && $urandom_range(0, 99) < 80) begin
            lh = HOURS_W'($urandom_range(0, 23));
            lm = MINSEC_W'($urandom_range(0, 59));
            ls = MINSEC_W'($urandom_range(0, 59));
        end
        send_request(act, lh, lm, ls, 1'b0, '0);
    endtask

    function automatic logic [ACTION_W-1:0] pick_edit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return ACT_UP;
        if (r < 44) return ACT_DOWN;
        if (r < 64) return ACT_RIGHT;
        if (r < 82) return ACT_LEFT;
        if (r < 87) return ACT_UNUSED;
        if (r < 91) return ACT_LOAD;
        if (r < 96) return ACT_CONFIRM;
        return ACT_EXIT;
    endfunction

    // result side: random stalls, quiet stretches, and long hold-offs
    initial begin
        int r;
        int quiet_cycles;
        int holds_done;
        quiet_cycles = 0;
        holds_done = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (holds_done < 2 && results_seen >= (holds_done == 0 ? 40 : 300)) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else if (quiet_cycles > 0) begin
                quiet_cycles--;
                i_out_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    quiet_cycles = $urandom_range(20, 80);
                    i_out_stall = 1'b0;
                end else if (r < 65) begin
                    i_out_stall = 1'b0;
                end else if (r < 97) begin
                    i_out_stall = 1'b1;
                end else begin
                    i_out_stall = 1'b1;
                    repeat ($urandom_range(5, 30)) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_shown want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_shown_q.size() == 0) begin
                report_mismatch("unexpected result, hours", o_shown_hours, 0);
            end else begin
                want = expected_shown_q.pop_front();
                if (o_shown_hours !== want.hours)
                    report_mismatch("shown_hours", o_shown_hours, want.hours);
                if (o_shown_minutes !== want.minutes)
                    report_mismatch("shown_minutes", o_shown_minutes, want.minutes);
                if (o_shown_seconds !== want.seconds)
                    report_mismatch("shown_seconds", o_shown_seconds, want.seconds);
                if (o_cursor_position !== want.cursor)
                    report_mismatch("cursor_position", o_cursor_position, want.cursor);
                if (o_commit !== want.commit)
                    report_mismatch("commit", o_commit, want.commit);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int n;
        mismatches     = 0;
        results_seen   = 0;
        requests_sent  = 0;
        quiet_requests = 0;
        ed_hours       = '0;
        ed_minutes     = '0;
        ed_seconds     = '0;
        ed_cursor      = POS_HOUR_T;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_LOAD;
        i_load_hours   = '0;
        i_load_minutes = '0;
        i_load_seconds = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[k]) begin
            send_request(script[k].act, script[k].lh, script[k].lm, script[k].ls,
                         script[k].typed, script[k].want);
        end

        // mostly edit sessions: load, edits, then confirm or exit; some noise
        while (requests_sent < NUM_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                send_random(ACT_LOAD);
                n = $urandom_range(3, 20);
                repeat (n) send_random(pick_edit());
                send_random($urandom_range(0, 1) ? ACT_CONFIRM : ACT_EXIT);
            end else begin
                send_random(ACTION_W'($urandom_range(0, 7)));
            end
        end
        i_in_valid = 1'b0;

        while (expected_shown_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
